### rtl/core/timer_and_scheduled_interrupt_unit_macros.svh
// Assertion macros shared by the timer and scheduled interrupt unit RTL.
// Expects clk and rst_n in the scope where the macros are used.
`ifndef TIMER_AND_SCHEDULED_INTERRUPT_UNIT_MACROS_SVH
`define TIMER_AND_SCHEDULED_INTERRUPT_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on the rising clock edge
`define TSIU_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tsiu assertion failed");

// Next-cycle implication, sampled on the rising clock edge
`define TSIU_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tsiu assertion failed");

`else

`define TSIU_ASSERT_IMP(label, ante, cons)
`define TSIU_ASSERT_NXT(label, ante, cons)

`endif

`endif

### rtl/core/tsiu_pkg.sv
// Package of the timer and scheduled interrupt unit: field widths, opcodes,
// the result record and the default schedule depth. No dependencies.
`default_nettype none

package tsiu_pkg;

    localparam int OPCODE_W = 2;
    localparam int PC_W     = 12;
    localparam int WORD_W   = 32;
    localparam int MASK_W   = 3;
    localparam int CLR_W    = 2;

    localparam int SCHEDULE_DEPTH_DEFAULT = 64;

    // Step opcodes
    localparam logic [OPCODE_W-1:0] OP_TICK   = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_RETURN = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_LOAD   = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_NOP    = 2'd3;

    // Bits of the enable and clear masks
    localparam int SRC_TIMER    = 0;
    localparam int SRC_EXT      = 1;
    localparam int SRC_SCHEDULE = 2;
    localparam int CLR_TIMER    = 0;
    localparam int CLR_SCHEDULE = 1;

    typedef struct packed {
        logic [PC_W-1:0]   next_pc;
        logic              interrupt_taken;
        logic [PC_W-1:0]   return_address;
        logic              timer_irq_pending;
        logic              schedule_irq_pending;
        logic [WORD_W-1:0] timer_value;
        logic              in_service;
    } rsp_t;

endpackage

`default_nettype wire

### rtl/core/tsiu_cmd_if.sv
// Command channel of the timer and scheduled interrupt unit: valid/ready
// handshake plus the step fields. Depends on tsiu_pkg.
`default_nettype none

interface tsiu_cmd_if;
    import tsiu_pkg::*;

    logic              valid;
    logic              ready;
    logic [OPCODE_W-1:0] opcode;
    logic [PC_W-1:0]   current_pc;
    logic [WORD_W-1:0] cycle_count;
    logic              ext_irq1_status;
    logic              timer_enable;
    logic [WORD_W-1:0] timer_limit;
    logic [MASK_W-1:0] irq_enable_mask;
    logic [PC_W-1:0]   handler_address;
    logic [CLR_W-1:0]  status_clear_mask;
    logic [WORD_W-1:0] schedule_value;

    modport source (
        output valid, opcode, current_pc, cycle_count, ext_irq1_status, timer_enable,
               timer_limit, irq_enable_mask, handler_address, status_clear_mask,
               schedule_value,
        input  ready
    );

    modport sink (
        input  valid, opcode, current_pc, cycle_count, ext_irq1_status, timer_enable,
               timer_limit, irq_enable_mask, handler_address, status_clear_mask,
               schedule_value,
        output ready
    );
endinterface

`default_nettype wire

### rtl/core/tsiu_rsp_if.sv
// Result channel of the timer and scheduled interrupt unit: valid/ready
// handshake plus the result fields. Depends on tsiu_pkg.
`default_nettype none

interface tsiu_rsp_if;
    import tsiu_pkg::*;

    logic              valid;
    logic              ready;
    logic [PC_W-1:0]   next_pc;
    logic              interrupt_taken;
    logic [PC_W-1:0]   return_address;
    logic              timer_irq_pending;
    logic              schedule_irq_pending;
    logic [WORD_W-1:0] timer_value;
    logic              in_service;

    modport source (
        output valid, next_pc, interrupt_taken, return_address, timer_irq_pending,
               schedule_irq_pending, timer_value, in_service,
        input  ready
    );

    modport sink (
        input  valid, next_pc, interrupt_taken, return_address, timer_irq_pending,
               schedule_irq_pending, timer_value, in_service,
        output ready
    );
endinterface

`default_nettype wire

### rtl/core/timer_and_scheduled_interrupt_unit.sv
// Top level of the timer and scheduled interrupt unit.
// Depends on tsiu_pkg, tsiu_cmd_if, tsiu_rsp_if, tsiu_ram and the macros header.
//
//   port | role   | carries
//   -----+--------+--------------------------------------------------------
//   cmd  | sink   | opcode, pc, cycle count, timer and interrupt controls
//   rsp  | source | next pc, taken flag, saved pc, status bits, timer value
//
// One item per cycle while rsp drains; accepted results are captured in the
// result register. The schedule head is prefetched from the RAM every cycle
// at the next pointer, with a write-through bypass for an entry loaded at
// the head. cmd.ready drops only while a result waits and rsp.ready is low.
// Reset clears the timer, status bits, pointers and service state; the
// schedule RAM has no reset and its head is used only below the fill count.
`default_nettype none

`include "timer_and_scheduled_interrupt_unit_macros.svh"

module timer_and_scheduled_interrupt_unit #(
    parameter int SCHEDULE_DEPTH = tsiu_pkg::SCHEDULE_DEPTH_DEFAULT
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    tsiu_cmd_if.sink   cmd,
    tsiu_rsp_if.source rsp
);
    import tsiu_pkg::*;

    localparam int AW = (SCHEDULE_DEPTH > 1) ? $clog2(SCHEDULE_DEPTH) : 1;
    localparam int CW = $clog2(SCHEDULE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(SCHEDULE_DEPTH);

    // State
    logic [WORD_W-1:0] timer_count_reg, timer_count_next;
    logic              timer_status_reg, timer_status_next;
    logic              sched_status_reg, sched_status_next;
    logic [CW-1:0]     sched_len_reg, sched_len_next;
    logic [CW-1:0]     sched_ptr_reg, sched_ptr_next;
    logic              service_reg, service_next;
    logic [PC_W-1:0]   saved_pc_reg, saved_pc_next;
    logic              byp_reg;
    logic [WORD_W-1:0] byp_data_reg;
    logic              out_valid_reg;
    rsp_t              out_reg, out_next;

    logic              accept;
    logic              ram_we;
    logic [WORD_W-1:0] ram_rdata;
    logic [WORD_W-1:0] sched_head;
    logic              pending;
    logic              taken;

    // Handshake: take an item whenever the result register is free or draining
    assign cmd.ready = !out_valid_reg || rsp.ready;
    assign accept    = cmd.valid && cmd.ready;

    // Schedule storage: append at the fill count, prefetch at the next pointer
    assign ram_we = accept && (cmd.opcode == OP_LOAD) && (sched_len_reg < DEPTH_C);

    tsiu_ram #(
        .WIDTH (WORD_W),
        .DEPTH (SCHEDULE_DEPTH)
    ) u_sched_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (sched_len_reg[AW-1:0]),
        .wdata (cmd.schedule_value),
        .raddr (sched_ptr_next[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign sched_head = byp_reg ? byp_data_reg : ram_rdata;

    // Step logic
    always_comb
    begin
        timer_count_next  = timer_count_reg;
        timer_status_next = timer_status_reg;
        sched_status_next = sched_status_reg;
        sched_len_next    = sched_len_reg;
        sched_ptr_next    = sched_ptr_reg;
        service_next      = service_reg;
        saved_pc_next     = saved_pc_reg;
        pending           = 1'b0;
        taken             = 1'b0;
        out_next.next_pc  = cmd.current_pc;

        if (accept)
        begin
            unique case (cmd.opcode)
                OP_TICK:
                begin
                    // Apply clears, then advance the timer and the schedule
                    if (cmd.status_clear_mask[CLR_TIMER])
                    begin
                        timer_status_next = 1'b0;
                    end
                    if (cmd.status_clear_mask[CLR_SCHEDULE])
                    begin
                        sched_status_next = 1'b0;
                    end
                    if (cmd.timer_enable)
                    begin
                        if (timer_count_reg >= cmd.timer_limit)
                        begin
                            timer_status_next = 1'b1;
                            timer_count_next  = '0;
                        end
                        else
                        begin
                            timer_count_next = timer_count_reg + WORD_W'(1);
                        end
                    end
                    if ((sched_ptr_reg < sched_len_reg) && (cmd.cycle_count == sched_head))
                    begin
                        sched_status_next = 1'b1;
                        sched_ptr_next    = sched_ptr_reg + CW'(1);
                    end
                    pending = (cmd.irq_enable_mask[SRC_TIMER] && timer_status_next)
                           || (cmd.irq_enable_mask[SRC_EXT] && cmd.ext_irq1_status)
                           || (cmd.irq_enable_mask[SRC_SCHEDULE] && sched_status_next);
                    taken = pending && !service_reg;
                    if (taken)
                    begin
                        out_next.next_pc = cmd.handler_address;
                    end
                end
                OP_RETURN:
                begin
                    // End service and check again; step the pc back if nothing is taken
                    pending = (cmd.irq_enable_mask[SRC_TIMER] && timer_status_reg)
                           || (cmd.irq_enable_mask[SRC_EXT] && cmd.ext_irq1_status)
                           || (cmd.irq_enable_mask[SRC_SCHEDULE] && sched_status_reg);
                    taken = pending;
                    service_next = 1'b0;
                    out_next.next_pc = taken ? cmd.handler_address
                                             : cmd.current_pc - PC_W'(1);
                end
                OP_LOAD:
                begin
                    if (sched_len_reg < DEPTH_C)
                    begin
                        sched_len_next = sched_len_reg + CW'(1);
                    end
                end
                default:
                begin
                    // no operation
                end
            endcase

            if (taken)
            begin
                service_next  = 1'b1;
                saved_pc_next = cmd.current_pc;
            end
        end

        out_next.interrupt_taken      = taken;
        out_next.return_address       = saved_pc_next;
        out_next.timer_irq_pending    = timer_status_next;
        out_next.schedule_irq_pending = sched_status_next;
        out_next.timer_value          = timer_count_next;
        out_next.in_service           = service_next;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_count_reg  <= '0;
            timer_status_reg <= 1'b0;
            sched_status_reg <= 1'b0;
            sched_len_reg    <= '0;
            sched_ptr_reg    <= '0;
            service_reg      <= 1'b0;
            saved_pc_reg     <= '0;
            byp_reg          <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            timer_count_reg  <= timer_count_next;
            timer_status_reg <= timer_status_next;
            sched_status_reg <= sched_status_next;
            sched_len_reg    <= sched_len_next;
            sched_ptr_reg    <= sched_ptr_next;
            service_reg      <= service_next;
            saved_pc_reg     <= saved_pc_next;
            // Forward an entry written at the address being prefetched
            byp_reg          <= ram_we && (sched_ptr_next == sched_len_reg);
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (ram_we)
        begin
            byp_data_reg <= cmd.schedule_value;
        end
        if (accept)
        begin
            out_reg <= out_next;
        end
    end

    // Drive the result channel
    assign rsp.valid                = out_valid_reg;
    assign rsp.next_pc              = out_reg.next_pc;
    assign rsp.interrupt_taken      = out_reg.interrupt_taken;
    assign rsp.return_address       = out_reg.return_address;
    assign rsp.timer_irq_pending    = out_reg.timer_irq_pending;
    assign rsp.schedule_irq_pending = out_reg.schedule_irq_pending;
    assign rsp.timer_value          = out_reg.timer_value;
    assign rsp.in_service           = out_reg.in_service;

    // Checks
    `TSIU_ASSERT_IMP(a_ptr_within_len, 1'b1, sched_ptr_reg <= sched_len_reg)
    `TSIU_ASSERT_IMP(a_len_within_depth, 1'b1, sched_len_reg <= DEPTH_C)
    `TSIU_ASSERT_IMP(a_taken_sets_service, rsp.valid && rsp.interrupt_taken, rsp.in_service)
    `TSIU_ASSERT_IMP(a_service_ends_on_return, $fell(service_reg), $past(accept && (cmd.opcode == OP_RETURN)))
    `TSIU_ASSERT_NXT(a_load_keeps_ptr, accept && (cmd.opcode == OP_LOAD), $stable(sched_ptr_reg))

endmodule

`default_nettype wire

### rtl/core/tsiu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tsiu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
